/* rtl/core/bandpk_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the 24-dot band packer.
// No dependencies; imported by every module of the core.
package bandpk_pkg;

   // band geometry
   localparam int BAND_ROWS = 24;
   localparam logic [4:0] BAND_LAST_ROW = 5'(BAND_ROWS - 1);
   localparam int STORE_W = BAND_ROWS - 1;
   localparam int COLUMN_W = BAND_ROWS;

   // luminance arithmetic, scaled by 100 so that it stays exact
   localparam int LUM_W = 15;
   localparam logic [LUM_W-1:0] WEIGHT_RED = 15'd30;
   localparam logic [LUM_W-1:0] WEIGHT_GREEN = 15'd59;
   localparam logic [LUM_W-1:0] WEIGHT_BLUE = 15'd11;
   localparam logic [LUM_W-1:0] THR_SCALE = 15'd100;

   // configuration port
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DARK_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAY_MODE = 2'd2;
   localparam logic [9:0] LINE_WIDTH_RESET = 10'd512;
   localparam logic [7:0] DARK_THRESHOLD_RESET = 8'd127;

   // queue between classifier and byte sequencer
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   // one completed band column on its way to the byte sequencer
   typedef struct packed {
      logic [COLUMN_W-1:0] bits;
      logic                first;
      logic                row_end;
   } band_entry_type;

endpackage

/* rtl/core/bandpk_front.sv */
`timescale 1ns / 1ps
// Front part: accepts pixels, derives the dark bit and keeps the column store.
// Depends on bandpk_pkg; feeds completed band columns to bandpk_queue.
module bandpk_front import bandpk_pkg::*; #(
   parameter int MAX_WIDTH = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [7:0]           req_red,
   input  logic [7:0]           req_green,
   input  logic [7:0]           req_blue,
   input  logic [9:0]           eff_width,
   input  logic [7:0]           dark_threshold,
   input  logic                 gray_mode,
   input  logic [QCNT_W-1:0]    q_count,
   output logic                 entry_valid,
   output band_entry_type       entry,
   output logic [1:0]           inflight
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic             accept;
   logic             row_end;

   logic [COL_W-1:0] col_ff, col_in;
   logic [4:0]       row_ff, row_in;

   // stage 1: raw pixel and its position
   logic             s1_valid_ff;
   logic [7:0]       s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [4:0]       s1_row_ff;
   logic             s1_row_end_ff;

   // stage 2: weighted luminance
   logic             s2_valid_ff;
   logic [LUM_W-1:0] s2_lum_ff, s2_thr100_ff;
   logic [7:0]       s2_red_ff;
   logic [COL_W-1:0] s2_col_ff;
   logic [4:0]       s2_row_ff;
   logic             s2_row_end_ff;

   // stage 3: column read back on the band row
   logic             s3_valid_ff;
   logic             s3_dark_ff, s3_first_ff, s3_row_end_ff;
   logic [STORE_W-1:0] rd_ff;

   logic               dark;
   logic               mem_we, mem_re;
   logic [4:0]         bit_pos;
   logic [STORE_W-1:0] mem_mask, mem_wdata;
   logic [STORE_W-1:0] store_mem [MAX_WIDTH];

   logic s1_band, s2_band;

   assign s1_band = s1_valid_ff && (s1_row_ff == BAND_LAST_ROW);
   assign s2_band = s2_valid_ff && (s2_row_ff == BAND_LAST_ROW);
   assign inflight = 2'({1'b0, s1_band} + {1'b0, s2_band} + {1'b0, s3_valid_ff});

   // only band-row words take queue space, so only they wait for credit
   assign req_full = (row_ff == BAND_LAST_ROW)
                     && ((4'(q_count) + 4'(inflight)) >= 4'(QUEUE_DEPTH));
   assign accept = req_push && !req_full;
   assign row_end = (32'(col_ff) + 32'd1) >= 32'(eff_width);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = (row_ff == BAND_LAST_ROW) ? 5'd0 : 5'(row_ff + 5'd1);
         end else begin
            col_in = COL_W'(col_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= mem_re;
      end
   end

   always_ff @(posedge clock) begin
      s1_red_ff <= req_red;
      s1_green_ff <= req_green;
      s1_blue_ff <= req_blue;
      s1_col_ff <= col_ff;
      s1_row_ff <= row_ff;
      s1_row_end_ff <= row_end;

      s2_lum_ff <= LUM_W'(s1_red_ff) * WEIGHT_RED + LUM_W'(s1_green_ff) * WEIGHT_GREEN
                   + LUM_W'(s1_blue_ff) * WEIGHT_BLUE;
      s2_thr100_ff <= LUM_W'(dark_threshold) * THR_SCALE;
      s2_red_ff <= s1_red_ff;
      s2_col_ff <= s1_col_ff;
      s2_row_ff <= s1_row_ff;
      s2_row_end_ff <= s1_row_end_ff;

      s3_dark_ff <= dark;
      s3_first_ff <= (s2_col_ff == '0);
      s3_row_end_ff <= s2_row_end_ff;
   end

   assign dark = gray_mode ? (s2_red_ff < dark_threshold) : (s2_lum_ff < s2_thr100_ff);

   // top row sits in the msb of the stored column
   assign bit_pos = 5'(STORE_W - 1) - s2_row_ff;
   assign mem_we = s2_valid_ff && (s2_row_ff != BAND_LAST_ROW);
   assign mem_re = s2_band;

   always_comb begin
      if (s2_row_ff == '0) begin
         // first row of a band starts the column afresh
         mem_mask = '1;
         mem_wdata = STORE_W'(dark) << bit_pos;
      end else begin
         mem_mask = STORE_W'(1) << bit_pos;
         mem_wdata = {STORE_W{dark}};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         for (int b = 0; b < STORE_W; b++) begin
            if (mem_mask[b]) begin
               store_mem[s2_col_ff][b] <= mem_wdata[b];
            end
         end
      end
      if (mem_re) begin
         rd_ff <= store_mem[s2_col_ff];
      end
   end

   assign entry_valid = s3_valid_ff;
   assign entry.bits = {rd_ff, s3_dark_ff};
   assign entry.first = s3_first_ff;
   assign entry.row_end = s3_row_end_ff;

endmodule

/* rtl/core/bandpk_queue.sv */
`timescale 1ns / 1ps
// Short queue of completed band columns between the front and the sequencer.
// Depends on bandpk_pkg for the entry type and depth.
module bandpk_queue import bandpk_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  band_entry_type    entry_in,
   input  logic              pop,
   output band_entry_type    entry_out,
   output logic              empty,
   output logic [QCNT_W-1:0] count
);

   band_entry_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   assign empty = (count_ff == '0);
   assign count = count_ff;
   assign entry_out = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= QPTR_W'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= QPTR_W'(rd_ptr_ff + 1'b1);
         end
         if (push && !pop) begin
            count_ff <= QCNT_W'(count_ff + 1'b1);
         end else if (pop && !push) begin
            count_ff <= QCNT_W'(count_ff - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

/* rtl/core/bandpk_emit.sv */
`timescale 1ns / 1ps
// Back part: turns queued band columns into command bytes, one word a cycle while the result side pops.
// Depends on bandpk_pkg; drives the result side through an output register.
module bandpk_emit import bandpk_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  band_entry_type q_entry,
   output logic           q_pop,
   input  logic [9:0]     eff_width,
   input  logic           rsp_pop,
   output logic           rsp_empty,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_last
);

   localparam logic [3:0] STEP_ESC = 4'd0;
   localparam logic [3:0] STEP_STAR = 4'd1;
   localparam logic [3:0] STEP_MODE = 4'd2;
   localparam logic [3:0] STEP_NL = 4'd3;
   localparam logic [3:0] STEP_NH = 4'd4;
   localparam logic [3:0] STEP_COL_HI = 4'd5;
   localparam logic [3:0] STEP_COL_MID = 4'd6;
   localparam logic [3:0] STEP_COL_LO = 4'd7;
   localparam logic [3:0] STEP_LF = 4'd8;

   localparam logic [7:0] BYTE_ESC = 8'h1B;
   localparam logic [7:0] BYTE_STAR = 8'h2A;
   localparam logic [7:0] BYTE_MODE = 8'd33;
   localparam logic [7:0] BYTE_LF = 8'h0A;

   logic           cur_valid_ff;
   band_entry_type cur_ff;
   logic [3:0]     step_ff;
   logic           out_valid_ff;
   logic [7:0]     out_byte_ff;
   logic           out_last_ff;

   logic       out_load, advance, done;
   logic [3:0] end_step;
   logic [7:0] step_byte;

   assign out_load = !out_valid_ff || rsp_pop;
   assign end_step = cur_ff.row_end ? STEP_LF : STEP_COL_LO;
   assign advance = cur_valid_ff && out_load;
   assign done = advance && (step_ff == end_step);
   assign q_pop = q_valid && (!cur_valid_ff || done);

   always_comb begin
      unique case (step_ff)
         STEP_ESC:     step_byte = BYTE_ESC;
         STEP_STAR:    step_byte = BYTE_STAR;
         STEP_MODE:    step_byte = BYTE_MODE;
         STEP_NL:      step_byte = eff_width[7:0];
         STEP_NH:      step_byte = {6'b0, eff_width[9:8]};
         STEP_COL_HI:  step_byte = cur_ff.bits[23:16];
         STEP_COL_MID: step_byte = cur_ff.bits[15:8];
         STEP_COL_LO:  step_byte = cur_ff.bits[7:0];
         STEP_LF:      step_byte = BYTE_LF;
         default:      step_byte = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff <= STEP_ESC;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            cur_valid_ff <= 1'b1;
            // header only ahead of the first column of a band
            step_ff <= q_entry.first ? STEP_ESC : STEP_COL_HI;
         end else if (done) begin
            cur_valid_ff <= 1'b0;
         end else if (advance) begin
            step_ff <= 4'(step_ff + 4'd1);
         end
         if (out_load) begin
            out_valid_ff <= advance;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_entry;
      end
      if (advance) begin
         out_byte_ff <= step_byte;
         out_last_ff <= (step_ff == end_step);
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last = out_last_ff;

endmodule

/* rtl/core/pixel_to_24dot_band_packer_core.sv */
`timescale 1ns / 1ps
// Pixel to 24-dot band packer: raster pixels in, bit-image command bytes out.
// A band-row pixel runs through stages 1 to 3, the queue and the sequencer to
// the output register. Throughput: one pixel a cycle on rows 0 to 22; band row:
// one byte a cycle while results are popped, three a pixel, five header bytes and
// a line feed. Synchronous reset clears position, queue and output.
module pixel_to_24dot_band_packer_core import bandpk_pkg::*; #(
   parameter int MAX_WIDTH = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [7:0]            req_red,
   input  logic [7:0]            req_green,
   input  logic [7:0]            req_blue,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [9:0] line_width_ff;
   logic [7:0] dark_threshold_ff;
   logic       gray_mode_ff;
   logic [9:0] eff_width;

   logic              q_push, q_pop, q_empty;
   band_entry_type    q_in, q_out;
   logic [QCNT_W-1:0] q_count;
   logic [1:0]        inflight;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         dark_threshold_ff <= DARK_THRESHOLD_RESET;
         gray_mode_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LINE_WIDTH:     line_width_ff <= csr_wdata;
            CSR_DARK_THRESHOLD: dark_threshold_ff <= csr_wdata[7:0];
            CSR_GRAY_MODE:      gray_mode_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // zero acts as one, anything past the store acts as the store size
   always_comb begin
      if (line_width_ff == '0) begin
         eff_width = 10'd1;
      end else if (32'(line_width_ff) > MAX_WIDTH) begin
         eff_width = 10'(MAX_WIDTH);
      end else begin
         eff_width = line_width_ff;
      end
   end

   bandpk_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .eff_width(eff_width),
      .dark_threshold(dark_threshold_ff),
      .gray_mode(gray_mode_ff),
      .q_count(q_count),
      .entry_valid(q_push),
      .entry(q_in),
      .inflight(inflight)
   );

   bandpk_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .entry_in(q_in),
      .pop(q_pop),
      .entry_out(q_out),
      .empty(q_empty),
      .count(q_count)
   );

   bandpk_emit u_emit (
      .clock(clock),
      .reset(reset),
      .q_valid(!q_empty),
      .q_entry(q_out),
      .q_pop(q_pop),
      .eff_width(eff_width),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last(rsp_last)
   );

   // credit scheme keeps queued plus in-flight band words within the queue
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      (4'(q_count) + 4'(inflight)) <= 4'(QUEUE_DEPTH))
      else $error("band words in flight exceed queue space");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
      else $error("push into a full column queue");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> rsp_empty)
      else $error("result word shown straight after reset");

endmodule

/* tb/band_packer_checker.sv */
`timescale 1ns / 1ps
// Checker for the 24-dot band packer: watches the pixel, byte and register channels,
// predicts the printer command stream and compares every popped word. Uses bandpk_pkg.
module band_packer_checker import bandpk_pkg::*; #(
   parameter int MAX_WIDTH = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  logic [7:0]            req_red,
   input  logic [7:0]            req_green,
   input  logic [7:0]            req_blue,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  logic [7:0]            rsp_out_byte,
   input  logic                  rsp_last,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    bytes_owed
);

   localparam logic [7:0] ESC_CODE       = 8'h1B;
   localparam logic [7:0] STAR_CODE      = 8'h2A;
   localparam logic [7:0] MODE_24_DOUBLE = 8'd33;
   localparam logic [7:0] LINE_FEED      = 8'h0A;

   typedef struct packed {
      logic [7:0] cmd_byte;
      logic       last;
   } cmd_word_type;

   cmd_word_type       cmd_bytes_q [$];
   logic [STORE_W-1:0] column_bits [MAX_WIDTH];
   logic [9:0]         width_q;
   logic [7:0]         thr_q;
   logic               gray_q;
   int unsigned        col_q;
   int unsigned        row_q;

   function automatic int unsigned band_columns(input logic [9:0] w);
      if (w == 0) return 1;
      if (w > MAX_WIDTH) return MAX_WIDTH;
      return w;
   endfunction

   task automatic queue_byte(input logic [7:0] v, input logic l);
      cmd_word_type word;
      word.cmd_byte = v;
      word.last = l;
      cmd_bytes_q.push_back(word);
   endtask

   task automatic pack_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      int unsigned         w;
      int unsigned         lum;
      logic                dark;
      logic                row_end;
      logic [COLUMN_W-1:0] bits;
      w = band_columns(width_q);
      if (gray_q) begin
         dark = (r < thr_q);
      end else begin
         // weights scaled by 100 so the comparison stays exact
         lum = 30 * r + 59 * g + 11 * b;
         dark = (lum < 100 * thr_q);
      end
      row_end = (col_q + 1 >= w);
      if (row_q < BAND_ROWS - 1) begin
         // first row of a band wipes whatever the column held before
         if (row_q == 0) column_bits[col_q] = '0;
         if (dark) column_bits[col_q][BAND_ROWS - 2 - row_q] = 1'b1;
      end else begin
         bits = {column_bits[col_q], dark};
         if (col_q == 0) begin
            queue_byte(ESC_CODE, 1'b0);
            queue_byte(STAR_CODE, 1'b0);
            queue_byte(MODE_24_DOUBLE, 1'b0);
            queue_byte(8'(w), 1'b0);
            queue_byte(8'(w >> 8), 1'b0);
         end
         queue_byte(bits[23:16], 1'b0);
         queue_byte(bits[15:8], 1'b0);
         queue_byte(bits[7:0], !row_end);
         if (row_end) queue_byte(LINE_FEED, 1'b1);
      end
      if (row_end) begin
         col_q = 0;
         row_q = (row_q + 1 >= BAND_ROWS) ? 0 : row_q + 1;
      end else begin
         col_q = col_q + 1;
      end
   endtask

   always @(posedge clock) begin
      cmd_word_type want;
      if (reset) begin
         width_q = LINE_WIDTH_RESET;
         thr_q = DARK_THRESHOLD_RESET;
         gray_q = 1'b0;
         col_q = 0;
         row_q = 0;
         cmd_bytes_q.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LINE_WIDTH:     width_q = csr_wdata[9:0];
               CSR_DARK_THRESHOLD: thr_q = csr_wdata[7:0];
               CSR_GRAY_MODE:      gray_q = csr_wdata[0];
               default:            ;
            endcase
         end
         if (req_push && !req_full) pack_pixel(req_red, req_green, req_blue);
         if (rsp_pop && !rsp_empty) begin
            if (cmd_bytes_q.size() == 0) begin
               $error("out_byte: expected no word, actual %02h", rsp_out_byte);
               mismatch_count++;
            end else begin
               want = cmd_bytes_q.pop_front();
               if (rsp_out_byte !== want.cmd_byte) begin
                  $error("out_byte mismatch: expected %02h, actual %02h",
                         want.cmd_byte, rsp_out_byte);
                  mismatch_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last mismatch: expected %0d, actual %0d", want.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
      end
      bytes_owed = cmd_bytes_q.size();
   end

endmodule

/* tb/pixel_to_24dot_band_packer_core_test.sv */
`timescale 1ns / 1ps
// Top of the band packer testbench: drives pixels, register writes and byte pops.
// Depends on bandpk_pkg, the packer core and band_packer_checker.
module pixel_to_24dot_band_packer_core_test;
   import bandpk_pkg::*;

   localparam int MAX_WIDTH = 512;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic [7:0]            req_red;
   logic [7:0]            req_green;
   logic [7:0]            req_blue;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_last;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatch_count;
   int                    bytes_owed;

   // stimulus side bookkeeping
   bit         gaps_on;
   bit         hold_req;
   bit         hold_done;
   int         t_col;
   int         t_row;
   int         random_sent;
   logic [9:0] cur_width;
   logic [7:0] cur_thr;
   logic       cur_gray;

   pixel_to_24dot_band_packer_core #(.MAX_WIDTH(MAX_WIDTH)) i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_out_byte(rsp_out_byte), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   band_packer_checker #(.MAX_WIDTH(MAX_WIDTH)) i_checker (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_out_byte(rsp_out_byte), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count), .bytes_owed(bytes_owed)
   );

   always #2 clock = ~clock;

   initial begin
      #2_400_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (!gaps_on || p < 60) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int print_columns(input logic [9:0] w);
      if (w == 0) return 1;
      if (w > MAX_WIDTH) return MAX_WIDTH;
      return w;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LINE_WIDTH:     cur_width = data[9:0];
         CSR_DARK_THRESHOLD: cur_thr = data[7:0];
         CSR_GRAY_MODE:      cur_gray = data[0];
         default:            ;
      endcase
      @(posedge clock);
   endtask

   // wait until every predicted word has been popped and the pipe has run dry
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (bytes_owed != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      int gap;
      int w;
      // stall the byte side just as the band row starts, so the core backs up
      if (!hold_done && t_row == BAND_ROWS - 1 && t_col == 0 && print_columns(cur_width) >= 6)
      begin
         hold_req = 1'b1;
         hold_done = 1'b1;
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      do @(posedge clock); while (req_full);
      w = print_columns(cur_width);
      if (t_col + 1 >= w) begin
         t_col = 0;
         t_row = (t_row + 1 >= BAND_ROWS) ? 0 : t_row + 1;
      end else begin
         t_col++;
      end
   endtask

   task automatic send_random_pixel();
      int         p;
      logic [7:0] lvl;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      p = $urandom_range(0, 99);
      lvl = (cur_thr != 0 && $urandom_range(0, 1) == 1) ? cur_thr - 8'd1 : cur_thr;
      if (p < 12) begin
         // right on the threshold, or one below it
         r = lvl;
         g = lvl;
         b = lvl;
      end else if (p < 20) begin
         r = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
         g = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
         b = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      end else begin
         r = 8'($urandom);
         g = 8'($urandom);
         b = 8'($urandom);
      end
      send_pixel(r, g, b);
      random_sent++;
   endtask

   // register change inside a band; the width only ever narrows here
   task automatic mid_event(input bit force_shrink);
      int k;
      settle();
      k = force_shrink ? 0 : $urandom_range(0, 2);
      if (k == 0) begin
         if (t_col > 0) write_reg(CSR_LINE_WIDTH, 10'($urandom_range(0, 1)));
      end else if (k == 1) begin
         write_reg(CSR_DARK_THRESHOLD, {2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))});
      end else begin
         write_reg(CSR_GRAY_MODE, {9'($urandom), ~cur_gray});
      end
   endtask

   initial begin
      int         gap;
      rsp_pop = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_pop <= 1'b0;
            repeat (600) @(posedge clock);
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   initial begin
      logic [7:0] gray_levels [8];
      int         phase;
      int         w;
      int         thr;
      int         gray;
      int         lead;
      int         event_at;
      int         count;
      bit         wide_run;
      gray_levels = '{8'h00, 8'hFF, 8'hFE, 8'h01, 8'h80, 8'h7F, 8'hAA, 8'h55};
      clock = 1'b0;
      reset = 1'b1;
      req_push = 1'b0;
      req_red = '0;
      req_green = '0;
      req_blue = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      gaps_on = 1'b1;
      hold_req = 1'b0;
      hold_done = 1'b0;
      t_col = 0;
      t_row = 0;
      random_sent = 0;
      cur_width = LINE_WIDTH_RESET;
      cur_thr = DARK_THRESHOLD_RESET;
      cur_gray = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero width acts as one column; gray samples against the top threshold
      write_reg(CSR_LINE_WIDTH, 10'd0);
      write_reg(CSR_DARK_THRESHOLD, 10'h3FF);
      write_reg(CSR_GRAY_MODE, 10'h3FF);
      write_reg(CSR_UNUSED_INDEX, 10'h2AA);
      for (int i = 0; i < BAND_ROWS; i++) begin
         send_pixel(gray_levels[i % 8], i[0] ? 8'hFF : 8'h00, i[1] ? 8'h00 : 8'hFF);
      end

      for (phase = 0; phase < 5 || random_sent < 230; phase++) begin
         settle();
         gaps_on = (phase != 1) && ($urandom_range(0, 3) != 0);
         wide_run = (phase == 2 || phase == 4);
         if (phase == 0) w = 6;
         else if (phase == 2) w = 1023;
         else if (phase == 4) w = 512;
         else w = $urandom_range(0, 1);
         if (phase == 1) thr = 0;
         else if (phase == 3) thr = 255;
         else thr = $urandom_range(0, 255);
         if (phase == 0) gray = 0;
         else if (phase == 1) gray = 1;
         else gray = $urandom_range(0, 1);
         write_reg(CSR_LINE_WIDTH, 10'(w));
         write_reg(CSR_DARK_THRESHOLD, {2'($urandom_range(0, 3)), 8'(thr)});
         write_reg(CSR_GRAY_MODE, {9'($urandom), 1'(gray)});
         if (phase == 3 || $urandom_range(0, 4) == 0) write_reg(CSR_UNUSED_INDEX, 10'($urandom));
         if (wide_run) begin
            // a few pixels at full width, then cut the row short
            lead = $urandom_range(3, 8);
            repeat (lead) send_random_pixel();
            mid_event(1'b1);
         end
         // the first band keeps its full width so the byte side can back up
         event_at = (phase != 0 && $urandom_range(0, 1) == 1) ? $urandom_range(1, 60) : -1;
         count = 0;
         do begin
            if (count == event_at) mid_event(1'b0);
            send_random_pixel();
            count++;
         end while (t_row != 0 || t_col != 0);
      end

      settle();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/bandpk_pkg.sv
rtl/core/bandpk_front.sv
rtl/core/bandpk_queue.sv
rtl/core/bandpk_emit.sv
rtl/core/pixel_to_24dot_band_packer_core.sv
tb/band_packer_checker.sv
tb/pixel_to_24dot_band_packer_core_test.sv
